[hw/rtl/script_line_normalizer_defines.svh]
// Assertion macros used by the line normaliser RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SCRIPT_LINE_NORMALIZER_DEFINES_SVH
`define SCRIPT_LINE_NORMALIZER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SLN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line normaliser check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SLN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line normaliser check failed");

`endif

[hw/rtl/sln_pkg.sv]
// Package for the script line normaliser: payload structs, codes and limits.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package sln_pkg;

  localparam int LEN_W = 8;
  localparam int NUM_W = 16;

  localparam logic [LEN_W-1:0] LINE_MAX_CHARS = 8'd128;
  localparam logic [NUM_W-1:0] LINE_NUM_MAX   = 16'hFFFF;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_EOL  = 2'd1;
  localparam logic [1:0] KIND_EOS  = 2'd2;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_stream;
  } sln_in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       out_char;
    logic [LEN_W-1:0] spaces_before;
    logic [LEN_W-1:0] line_length;
    logic [NUM_W-1:0] line_number;
  } sln_out_t;

  // Outcome of one step of the line logic.
  typedef struct packed {
    logic     emit;
    sln_out_t res;
  } sln_step_t;

endpackage

[hw/rtl/sln_in_stage.sv]
// Input register of the script line normaliser.
// Holds one accepted transaction until the line logic consumes it; uses sln_pkg.
`timescale 1ns / 1ps

module sln_in_stage
  import sln_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  sln_in_t in_data,
  input  logic    take,
  output logic    hold_valid,
  output sln_in_t hold_data
);

  logic    valid_r;
  logic    valid_nxt;
  sln_in_t data_r;

  assign in_ready   = !valid_r || take;
  assign hold_valid = valid_r;
  assign hold_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

[hw/rtl/sln_line_core.sv]
// Line state and per-character cleaning logic of the script line normaliser.
// Uses sln_pkg and the assertion macros of script_line_normalizer_defines.svh.
`timescale 1ns / 1ps
`include "script_line_normalizer_defines.svh"

module sln_line_core
  import sln_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  sln_in_t   item,
  input  logic      advance,
  output sln_step_t step
);

  logic             comments_en_r;
  logic             quote_open_r,      quote_open_nxt;
  logic             comment_skip_r,    comment_skip_nxt;
  logic [LEN_W-1:0] stored_length_r,   stored_length_nxt;
  logic [LEN_W-1:0] held_spaces_r,     held_spaces_nxt;
  logic             first_was_space_r, first_was_space_nxt;
  logic             line_open_r,       line_open_nxt;
  logic [NUM_W-1:0] lines_done_r,      lines_done_nxt;

  logic [7:0]       ch;
  logic             is_space;
  logic             finish;
  logic             keep;
  logic [NUM_W-1:0] lines_inc;

  assign ch        = (item.char_code == CH_TAB) ? CH_SPACE : item.char_code;
  assign is_space  = (ch == CH_SPACE);
  assign lines_inc = (lines_done_r != LINE_NUM_MAX) ? lines_done_r + 16'd1 : lines_done_r;

  always_comb begin
    quote_open_nxt      = quote_open_r;
    comment_skip_nxt    = comment_skip_r;
    stored_length_nxt   = stored_length_r;
    held_spaces_nxt     = held_spaces_r;
    first_was_space_nxt = first_was_space_r;
    line_open_nxt       = line_open_r;
    lines_done_nxt      = lines_done_r;
    finish              = 1'b0;
    keep                = 1'b0;
    step                = '0;
    step.res.line_number = lines_done_r;

    if (item.end_of_stream) begin
      if (line_open_r) begin
        finish = 1'b1;
      end else begin
        step.emit     = 1'b1;
        step.res.kind = KIND_EOS;
      end
    end else begin
      line_open_nxt = 1'b1;
      if (item.char_code == CH_NL) begin
        finish = 1'b1;
      end else if (!comment_skip_r) begin
        if (item.char_code == CH_QUOTE) begin
          quote_open_nxt = !quote_open_r;
          keep           = 1'b1;
        end else if (!quote_open_r && item.char_code == CH_SEMI && comments_en_r) begin
          comment_skip_nxt = 1'b1;
        end else begin
          keep = 1'b1;
        end
      end
    end

    // A second leading space is dropped, and so is anything past the line limit.
    if (keep && !(stored_length_r == 8'd1 && is_space && first_was_space_r)
        && stored_length_r < LINE_MAX_CHARS) begin
      if (stored_length_r == '0) begin
        first_was_space_nxt = is_space;
      end
      stored_length_nxt = stored_length_r + 8'd1;
      if (is_space) begin
        held_spaces_nxt = held_spaces_r + 8'd1;
      end else begin
        step.emit              = 1'b1;
        step.res.kind          = KIND_CHAR;
        step.res.out_char      = ch;
        step.res.spaces_before = held_spaces_r;
        held_spaces_nxt        = '0;
      end
    end

    if (finish) begin
      lines_done_nxt       = lines_inc;
      step.emit            = 1'b1;
      step.res.kind        = KIND_EOL;
      step.res.line_number = lines_inc;
      step.res.line_length = (stored_length_r >= held_spaces_r) ?
                             stored_length_r - held_spaces_r : '0;
      quote_open_nxt       = 1'b0;
      comment_skip_nxt     = 1'b0;
      stored_length_nxt    = '0;
      held_spaces_nxt      = '0;
      first_was_space_nxt  = 1'b0;
      line_open_nxt        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comments_en_r     <= 1'b1;
      quote_open_r      <= 1'b0;
      comment_skip_r    <= 1'b0;
      stored_length_r   <= '0;
      held_spaces_r     <= '0;
      first_was_space_r <= 1'b0;
      line_open_r       <= 1'b0;
      lines_done_r      <= '0;
    end else begin
      if (cfg_we) begin
        comments_en_r <= cfg_wdata;
      end
      if (advance) begin
        quote_open_r      <= quote_open_nxt;
        comment_skip_r    <= comment_skip_nxt;
        stored_length_r   <= stored_length_nxt;
        held_spaces_r     <= held_spaces_nxt;
        first_was_space_r <= first_was_space_nxt;
        line_open_r       <= line_open_nxt;
        lines_done_r      <= lines_done_nxt;
      end
    end
  end

  // Held spaces are always part of the stored length, which never passes the limit.
  `SLN_ASSERT_NOW(a_held_within_len, 1'b1, held_spaces_r <= stored_length_r)
  `SLN_ASSERT_NOW(a_len_limit, 1'b1, stored_length_r <= LINE_MAX_CHARS)
  // A comment can only be running inside an open line.
  `SLN_ASSERT_NOW(a_comment_in_line, comment_skip_r, line_open_r)
  // Ending a line clears the per-line state.
  `SLN_ASSERT_NEXT(a_eol_clears, advance && step.emit && step.res.kind == KIND_EOL,
                   stored_length_r == '0 && !line_open_r && !comment_skip_r)

endmodule

[hw/rtl/sln_out_stage.sv]
// Result register of the script line normaliser.
// Holds one result transaction until the consumer takes it; uses sln_pkg.
`timescale 1ns / 1ps

module sln_out_stage
  import sln_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  sln_out_t load_data,
  output logic     slot_free,
  output logic     out_valid,
  input  logic     out_ready,
  output sln_out_t out_data
);

  logic     valid_r;
  logic     valid_nxt;
  sln_out_t data_r;

  assign slot_free = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

[hw/rtl/script_line_normalizer.sv]
// The input register holds each accepted byte while the line logic works on it; a byte with a
// result loads it into the result register as the byte moves on, and the consumer takes it there.
// Throughput: one byte per cycle; bytes that give no result never wait for the output.
// The only stall comes from a full result register that the consumer does not take.
// Reset (rst_n, synchronous, active low) empties both registers, clears the line
// state and the line count, and turns comment stripping on.
`timescale 1ns / 1ps

module script_line_normalizer
  import sln_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  input  logic     in_valid,
  output logic     in_ready,
  input  sln_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sln_out_t out_data
);

  logic      hold_valid;
  sln_in_t   hold_data;
  logic      slot_free;
  logic      take;
  sln_step_t step;

  // The held byte moves on unless it has a result and the result register is blocked.
  assign take = hold_valid && (!step.emit || slot_free);

  sln_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_data  (hold_data)
  );

  sln_line_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (hold_data),
    .advance   (take),
    .step      (step)
  );

  sln_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && step.emit),
    .load_data (step.res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[tb/tb_script_line_normalizer.sv]
// Self-checking testbench for the script line normaliser: directed and random byte streams,
// a line-by-line predictor and a checker on every result transaction.
// Depends on sln_pkg and the script_line_normalizer RTL only.
`timescale 1ns / 1ps

module tb_script_line_normalizer;
  import sln_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int DRAIN_CYCLES   = 6;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     cfg_we    = 1'b0;
  logic     cfg_wdata = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  sln_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  sln_out_t out_data;

  script_line_normalizer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #CLK_HALF clk = ~clk;

  sln_in_t     pending_bytes[$];
  sln_out_t    expected_results[$];
  int          send_idle_pct = 10;
  int          recv_idle_pct = 78;
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;
  sln_out_t    oldest_result;

  // Predictor copy of the configuration and the line state.
  logic        strip_comments = 1'b1;
  logic        quoted         = 1'b0;
  logic        in_comment     = 1'b0;
  logic        lead_space     = 1'b0;
  logic        line_pending   = 1'b0;
  logic [7:0]  kept_len       = 8'd0;
  logic [7:0]  pending_spaces = 8'd0;
  logic [15:0] lines_seen     = 16'd0;

  function automatic void expect_result(logic [1:0] kind, logic [7:0] ch,
                                        logic [7:0] spaces, logic [7:0] len);
    sln_out_t r;
    r.kind          = kind;
    r.out_char      = ch;
    r.spaces_before = spaces;
    r.line_length   = len;
    r.line_number   = lines_seen;
    expected_results.push_back(r);
  endfunction

  function automatic void close_line();
    logic [7:0] len;
    len = (kept_len >= pending_spaces) ? kept_len - pending_spaces : 8'd0;
    if (lines_seen != LINE_NUM_MAX) lines_seen++;
    expect_result(KIND_EOL, 8'd0, 8'd0, len);
    quoted         = 1'b0;
    in_comment     = 1'b0;
    kept_len       = 8'd0;
    pending_spaces = 8'd0;
    lead_space     = 1'b0;
    line_pending   = 1'b0;
  endfunction

  function automatic void predict_byte(sln_in_t item);
    logic [7:0] c;
    c = item.char_code;
    if (item.end_of_stream) begin
      if (line_pending) close_line();
      else expect_result(KIND_EOS, 8'd0, 8'd0, 8'd0);
      return;
    end
    line_pending = 1'b1;
    if (c == CH_NL) begin
      close_line();
      return;
    end
    if (in_comment) return;
    if (c == CH_QUOTE) begin
      quoted = !quoted;
    end else if (!quoted && c == CH_SEMI && strip_comments) begin
      in_comment = 1'b1;
      return;
    end
    if (c == CH_TAB) c = CH_SPACE;
    // A second blank straight after a leading blank is squeezed out.
    if (kept_len == 8'd1 && c == CH_SPACE && lead_space) return;
    if (kept_len >= LINE_MAX_CHARS) return;
    if (kept_len == 8'd0) lead_space = (c == CH_SPACE);
    kept_len++;
    if (c == CH_SPACE) begin
      pending_spaces++;
      return;
    end
    expect_result(KIND_CHAR, c, pending_spaces, 8'd0);
    pending_spaces = 8'd0;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // Driver: the prediction is made at the edge where the input transaction is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_byte(in_data);
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result transaction is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $error("result with nothing expected: kind %0d char %0d",
                 out_data.kind, out_data.out_char);
        end else begin
          oldest_result = expected_results.pop_front();
          check_field("kind", 16'(oldest_result.kind), 16'(out_data.kind));
          check_field("out_char", 16'(oldest_result.out_char), 16'(out_data.out_char));
          check_field("spaces_before", 16'(oldest_result.spaces_before),
                      16'(out_data.spaces_before));
          check_field("line_length", 16'(oldest_result.line_length),
                      16'(out_data.line_length));
          check_field("line_number", oldest_result.line_number, out_data.line_number);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[script_line_normalizer] ERROR");
      $finish;
    end
  end

  function automatic void push_byte(logic [7:0] c, logic eos);
    sln_in_t item;
    item.char_code     = c;
    item.end_of_stream = eos;
    pending_bytes.push_back(item);
  endfunction

  function automatic logic [7:0] random_char();
    case ($urandom_range(9))
      0, 1:    return CH_SPACE;
      2:       return CH_TAB;
      3:       return CH_QUOTE;
      4:       return CH_SEMI;
      5:       return 8'($urandom_range(255));
      default: return 8'($urandom_range(126, 33));
    endcase
  endfunction

  // Mostly well-formed lines with random content; now and then a long line that can
  // pass the line limit, or one or two end-of-stream marks in place of the newline.
  task automatic push_random_lines(input int target);
    int added, len, lead, ending;
    added = 0;
    while (added < target) begin
      len  = ($urandom_range(19) == 0) ? $urandom_range(200, 120) : $urandom_range(16, 0);
      lead = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
      repeat (lead) push_byte($urandom_range(1) ? CH_TAB : CH_SPACE, 1'b0);
      repeat (len) push_byte(random_char(), 1'b0);
      ending = $urandom_range(19);
      if (ending == 0) begin
        push_byte(8'($urandom), 1'b1);
      end else if (ending == 1) begin
        push_byte(8'($urandom), 1'b1);
        push_byte(8'($urandom), 1'b1);
      end else begin
        push_byte(CH_NL, 1'b0);
      end
      added += lead + len + 1;
    end
  endtask

  // Waits until every transaction has gone through, then lets the pipeline settle.
  // The check is made at the falling edge, once the driver's updates have landed.
  task automatic drain();
    @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_comments(input logic enable);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= enable;
    @(posedge clk);
    cfg_we    <= 1'b0;
    strip_comments = enable;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_comments(1'b1);

    // Stream end with no line open, then an empty line.
    push_byte(8'h00, 1'b1);
    push_byte(CH_NL, 1'b0);
    // Leading blanks are squeezed, inner blanks are held, a comment swallows the tail.
    push_byte(CH_SPACE, 1'b0);
    push_byte(CH_SPACE, 1'b0);
    push_byte(CH_TAB, 1'b0);
    push_byte("A", 1'b0);
    push_byte(CH_SPACE, 1'b0);
    push_byte(CH_TAB, 1'b0);
    push_byte("b", 1'b0);
    push_byte(CH_SPACE, 1'b0);
    push_byte(CH_SEMI, 1'b0);
    push_byte("z", 1'b0);
    push_byte(CH_NL, 1'b0);
    // A semicolon inside quotes is an ordinary character.
    push_byte(CH_QUOTE, 1'b0);
    push_byte(CH_SEMI, 1'b0);
    push_byte(CH_QUOTE, 1'b0);
    push_byte(CH_NL, 1'b0);
    // Extreme byte values, then a stream end that closes the open line and one more.
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b1);
    drain();

    set_comments(1'b0);
    push_random_lines(400);
    drain();

    send_idle_pct = 78;
    recv_idle_pct = 10;
    set_comments(1'b1);
    push_random_lines(500);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_comments(1'b0);
    push_random_lines(300);
    drain();

    set_comments(1'b1);
    push_random_lines(200);
    push_random_lines(100);
    drain();

    if (fail_count == 0) begin
      $display("[script_line_normalizer] OK");
    end else begin
      $display("[script_line_normalizer] ERROR");
    end
    $finish;
  end

endmodule
